>>> hw/rtl/bsge_pkg.sv
// ----------------------------------------------------------------------------
// bsge_pkg: shared types and constants
// Widths, register indexes, phase codes, config struct and curve function.
// ----------------------------------------------------------------------------
package bsge_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned LEVEL_W    = 17;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned MUL_W      = 21;
  localparam int unsigned PROD_W     = 2 * MUL_W;

  localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH_ON_BEAT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_TOL      = 3'd7;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ATTACK  = 2'd1;
  localparam logic [1:0] PH_HOLD    = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SYNC = 1'b1;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'd65536;

  localparam logic [POS_W-1:0]   RST_BEAT_PERIOD   = 32'd6144000;
  localparam logic [LEN_W-1:0]   RST_ATTACK_LEN    = 20'd16080;
  localparam logic [LEN_W-1:0]   RST_HOLD_LEN      = 20'd11880;
  localparam logic [LEN_W-1:0]   RST_RELEASE_LEN   = 20'd480;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL = 17'd46531;
  localparam logic [TOL_W-1:0]   RST_SYNC_TOL      = 16'd61440;

  typedef struct packed {
    logic [POS_W-1:0]   beat_period;
    logic [LEN_W-1:0]   attack_len;
    logic [LEN_W-1:0]   hold_len;
    logic [LEN_W-1:0]   release_len;
    logic [LEVEL_W-1:0] sustain_level;
    logic               gate_enable;
    logic               flush_on_beat;
    logic [TOL_W-1:0]   sync_tolerance;
  } cfg_t;

  // 1 - exp(-x) in Q16, x in Q31; elaboration-time only
  function automatic logic [LEVEL_W-1:0] curve_entry(input logic [63:0] x);
    logic [63:0] one;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] y3;
    logic [63:0] y4;
    logic [63:0] e;
    logic [63:0] q16;
    one = 64'd1 << 31;
    y   = x >> 8;
    y2  = (y * y) >> 31;
    y3  = (y2 * y) >> 31;
    y4  = (y3 * y) >> 31;
    e   = one - y + y2 / 64'd2 - y3 / 64'd6 + y4 / 64'd24;
    for (int k = 0; k < 8; k++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    if (e > one) begin
      e = one;
    end
    q16 = (e + (64'd1 << 14)) >> 15;
    if (q16 > 64'(FULL_LEVEL)) begin
      q16 = 64'(FULL_LEVEL);
    end
    return LEVEL_W'(64'(FULL_LEVEL) - q16);
  endfunction

endpackage

>>> hw/rtl/bsge_if.sv
// ----------------------------------------------------------------------------
// bsge_if: channel interfaces
// Input, result and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface bsge_in_if;
  import bsge_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic             playing;
  logic [POS_W-1:0] sync_position;
  modport source (output valid, cmd, playing, sync_position, input ready);
  modport sink (input valid, cmd, playing, sync_position, output ready);
endinterface

interface bsge_out_if;
  import bsge_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] gate_level;
  logic [1:0]         env_phase;
  logic               flush_request;
  modport source (output valid, gate_level, env_phase, flush_request, input ready);
  modport sink (input valid, gate_level, env_phase, flush_request, output ready);
endinterface

interface bsge_cfg_if;
  import bsge_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bsge_cfg.sv
// ----------------------------------------------------------------------------
// bsge_cfg: configuration registers
// Holds the eight gate settings, written one beat at a time.
// ----------------------------------------------------------------------------
module bsge_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  bsge_cfg_if.sink      cfg_i,
  output bsge_pkg::cfg_t cfg_o
);
  import bsge_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_BEAT_PERIOD:   cfg_d.beat_period    = cfg_i.data;
        REG_ATTACK_LEN:    cfg_d.attack_len     = cfg_i.data[LEN_W-1:0];
        REG_HOLD_LEN:      cfg_d.hold_len       = cfg_i.data[LEN_W-1:0];
        REG_RELEASE_LEN:   cfg_d.release_len    = cfg_i.data[LEN_W-1:0];
        REG_SUSTAIN_LEVEL: cfg_d.sustain_level  = cfg_i.data[LEVEL_W-1:0];
        REG_GATE_ENABLE:   cfg_d.gate_enable    = cfg_i.data[0];
        REG_FLUSH_ON_BEAT: cfg_d.flush_on_beat  = cfg_i.data[0];
        REG_SYNC_TOL:      cfg_d.sync_tolerance = cfg_i.data[TOL_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beat_period    <= RST_BEAT_PERIOD;
      cfg_q.attack_len     <= RST_ATTACK_LEN;
      cfg_q.hold_len       <= RST_HOLD_LEN;
      cfg_q.release_len    <= RST_RELEASE_LEN;
      cfg_q.sustain_level  <= RST_SUSTAIN_LEVEL;
      cfg_q.gate_enable    <= 1'b1;
      cfg_q.flush_on_beat  <= 1'b0;
      cfg_q.sync_tolerance <= RST_SYNC_TOL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/bsge_div.sv
// ----------------------------------------------------------------------------
// bsge_div: serial restoring divider
// One quotient bit per cycle; dividend is the product of the shared multiplier.
// ----------------------------------------------------------------------------
module bsge_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bsge_pkg::PROD_W-1:0]  dividend_i,
  input  logic [bsge_pkg::LEN_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [bsge_pkg::PROD_W-1:0]  quot_o,
  output logic [bsge_pkg::LEN_W-1:0]   rem_o
);
  import bsge_pkg::*;

  localparam int unsigned CntW = $clog2(PROD_W);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [PROD_W-1:0] quot_q;
  logic [LEN_W-1:0]  rem_q;
  logic [LEN_W-1:0]  dvs_q;
  logic [LEN_W:0]    rem_shift;
  logic              take;
  logic [LEN_W:0]    rem_next;

  assign rem_shift = {rem_q, quot_q[PROD_W-1]};
  assign take      = rem_shift >= {1'b0, dvs_q};
  assign rem_next  = take ? rem_shift - {1'b0, dvs_q} : rem_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(PROD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[PROD_W-2:0], take};
      rem_q  <= rem_next[LEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/bsge_curve_rom.sv
// ----------------------------------------------------------------------------
// bsge_curve_rom: release curve table
// 1-exp(-4.5t) in Q16, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module bsge_curve_rom #(
  parameter int unsigned CURVE_ENTRIES = 256
) (
  input  logic                               clk_i,
  input  logic [$clog2(CURVE_ENTRIES)-1:0]   addr_i,
  output logic [bsge_pkg::LEVEL_W-1:0]       data_o
);
  import bsge_pkg::*;

  localparam int unsigned Last = CURVE_ENTRIES - 1;

  logic [LEVEL_W-1:0] tbl [CURVE_ENTRIES];
  logic [LEVEL_W-1:0] data_q;

  for (genvar i = 0; i < CURVE_ENTRIES; i++) begin : g_tbl
    localparam logic [63:0] XArg = ((64'd9 << 30) * 64'(i)) / 64'(Last);
    assign tbl[i] = curve_entry(XArg);
  end

  always_ff @(posedge clk_i) begin
    data_q <= tbl[addr_i];
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/beat_synced_gate_envelope_top.sv
// ----------------------------------------------------------------------------
// beat_synced_gate_envelope_top: tempo-synced gate envelope
// Beat timer, attack/hold/release sequencer, shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one beat per audio sample tick (cmd 0) or transport sync (cmd 1).
//   out_o  : one beat per input beat: gate_level (Q1.16), env_phase, flush.
//   cfg_i  : register writes, always ready; write only while the block is idle.
// Path from accept to result valid, by kind of beat:
//   stopped or gate-off ticks: straight to the result; sync beats: through the sync check
//   ticks in idle or hold, or that end attack or release: beat timer update, then phase step
//   attack ramp ticks: timer update and phase step, then one 42-step divide
//   release curve ticks: two 42-step divides, two table reads,
//   and the final scaling multiply
// The serial divider computes one quotient bit per cycle.
// in_i.ready is high only while the sequencer waits for a beat; a new beat
// may be taken while the previous result still sits in the output register.
// The next beat can be taken in the cycle after the result loads.
// If the receiver stalls, the finished result waits for the output register
// and the block takes nothing more until it frees up.
// Reset loads the default settings and clears timer, phase and level state.
// ----------------------------------------------------------------------------
module beat_synced_gate_envelope_top #(
  parameter int unsigned CURVE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsge_in_if.sink    in_i,
  bsge_out_if.source out_o,
  bsge_cfg_if.sink   cfg_i
);
  import bsge_pkg::*;

  localparam int unsigned     CurveIdxW = $clog2(CURVE_ENTRIES);
  localparam logic [MUL_W-1:0] CurveLast = MUL_W'(CURVE_ENTRIES - 1);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_PRE      = 5'd1;
  localparam logic [4:0] ST_SYNC     = 5'd2;
  localparam logic [4:0] ST_TICK     = 5'd3;
  localparam logic [4:0] ST_STEP     = 5'd4;
  localparam logic [4:0] ST_ATK_MD   = 5'd5;
  localparam logic [4:0] ST_ATK_W    = 5'd6;
  localparam logic [4:0] ST_REL_MD1  = 5'd7;
  localparam logic [4:0] ST_REL_W1   = 5'd8;
  localparam logic [4:0] ST_REL_RDA  = 5'd9;
  localparam logic [4:0] ST_REL_RDB  = 5'd10;
  localparam logic [4:0] ST_REL_DIFF = 5'd11;
  localparam logic [4:0] ST_REL_MD2  = 5'd12;
  localparam logic [4:0] ST_REL_W2   = 5'd13;
  localparam logic [4:0] ST_REL_MUL3 = 5'd14;
  localparam logic [4:0] ST_REL_LVL  = 5'd15;
  localparam logic [4:0] ST_FIN      = 5'd16;

  cfg_t cfg;

  logic [4:0]         state_q, state_d;
  logic [POS_W-1:0]   bc_q, bc_d;
  logic [1:0]         phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               run_q, run_d;
  logic               flush_q, flush_d;
  logic               out_valid_q, out_valid_d;

  logic               cmd_q;
  logic               play_q;
  logic [POS_W-1:0]   pos_q;
  logic [CurveIdxW-1:0] idx_q, idx_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  logic [LEVEL_W-1:0] a_q, a_d;
  logic [LEVEL_W-1:0] diff_q, diff_d;
  logic [LEVEL_W-1:0] cv_q, cv_d;
  logic [32:0]        prod_q, prod_d;
  logic [LEVEL_W-1:0] out_level_q;
  logic [1:0]         out_phase_q;
  logic               out_flush_q;

  logic               in_fire;
  logic               out_load;
  logic [LEVEL_W-1:0] sus;
  logic [LEVEL_W-1:0] span;
  logic [CNT_W-1:0]   cnt_inc;
  logic [POS_W:0]     tick_sum;
  logic               tick_wrap;
  logic [POS_W:0]     tick_res;
  logic [POS_W-1:0]   sync_diff;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               div_start;
  logic [LEN_W-1:0]   div_dvs;
  logic               div_done;
  logic [PROD_W-1:0]  div_quot;
  logic [LEN_W-1:0]   div_rem;
  logic [CurveIdxW-1:0] rom_addr;
  logic [LEVEL_W-1:0] rom_data;
  logic [LEVEL_W-1:0] lvl_fin;
  logic [1:0]         ph_fin;

  bsge_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bsge_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  bsge_curve_rom #(
    .CURVE_ENTRIES (CURVE_ENTRIES)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && (state_q == ST_IDLE);

  assign sus  = (cfg.sustain_level > FULL_LEVEL) ? FULL_LEVEL : cfg.sustain_level;
  assign span = FULL_LEVEL - sus;

  assign cnt_inc   = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
  assign tick_sum  = {1'b0, bc_q} + 33'd256;
  assign tick_wrap = tick_sum >= {1'b0, cfg.beat_period};
  assign tick_res  = tick_wrap ? tick_sum - {1'b0, cfg.beat_period} : tick_sum;
  assign sync_diff = (pos_q > bc_q) ? pos_q - bc_q : bc_q - pos_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_ATK_MD: begin
        mul_a = MUL_W'(span);
        mul_b = cnt_q;
      end
      ST_REL_MD1: begin
        mul_a = cnt_q;
        mul_b = CurveLast;
      end
      ST_REL_MD2: begin
        mul_a = MUL_W'(diff_q);
        mul_b = MUL_W'(rem_q);
      end
      ST_REL_MUL3: begin
        mul_a = MUL_W'(span);
        mul_b = MUL_W'(cv_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign div_start = (state_q == ST_ATK_MD) || (state_q == ST_REL_MD1) ||
                     (state_q == ST_REL_MD2);
  assign div_dvs   = (state_q == ST_ATK_MD) ? cfg.attack_len : cfg.release_len;
  assign rom_addr  = (state_q == ST_REL_RDA) ? idx_q : idx_q + CurveIdxW'(1);

  assign lvl_fin = cfg.gate_enable ? level_q : FULL_LEVEL;
  assign ph_fin  = cfg.gate_enable ? phase_q : PH_IDLE;

  always_comb begin
    state_d     = state_q;
    bc_d        = bc_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    level_d     = level_q;
    run_d       = run_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_load    = 1'b0;
    idx_d       = idx_q;
    rem_d       = rem_q;
    a_d         = a_q;
    diff_d      = diff_q;
    cv_d        = cv_q;
    prod_d      = prod_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        flush_d = 1'b0;
        if (!play_q && run_q) begin
          bc_d = '0;
          if (phase_q != PH_IDLE) begin
            phase_d = PH_RELEASE;
            cnt_d   = '0;
          end
        end
        run_d = play_q;
        if (cmd_q == CMD_SYNC) begin
          state_d = ST_SYNC;
        end else if (cfg.gate_enable && play_q) begin
          state_d = ST_TICK;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SYNC: begin
        if (play_q && (cfg.beat_period != '0) && (sync_diff > POS_W'(cfg.sync_tolerance))) begin
          bc_d = pos_q;
        end
        state_d = ST_FIN;
      end
      ST_TICK: begin
        if (tick_wrap) begin
          phase_d = PH_ATTACK;
          cnt_d   = '0;
          level_d = sus;
          flush_d = cfg.flush_on_beat;
        end
        bc_d    = tick_res[POS_W] ? '1 : tick_res[POS_W-1:0];
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cnt_d   = cnt_inc;
        state_d = ST_FIN;
        unique case (phase_q)
          PH_IDLE: begin
            level_d = sus;
          end
          PH_ATTACK: begin
            if (cnt_inc >= CNT_W'(cfg.attack_len)) begin
              level_d = FULL_LEVEL;
              phase_d = PH_HOLD;
              cnt_d   = '0;
            end else begin
              state_d = ST_ATK_MD;
            end
          end
          PH_HOLD: begin
            level_d = FULL_LEVEL;
            if (cnt_inc >= CNT_W'(cfg.hold_len)) begin
              phase_d = PH_RELEASE;
              cnt_d   = '0;
            end
          end
          PH_RELEASE: begin
            if (cnt_inc >= CNT_W'(cfg.release_len)) begin
              level_d = sus;
              phase_d = PH_IDLE;
              cnt_d   = '0;
            end else begin
              state_d = ST_REL_MD1;
            end
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_ATK_MD: begin
        state_d = ST_ATK_W;
      end
      ST_ATK_W: begin
        if (div_done) begin
          level_d = sus + div_quot[LEVEL_W-1:0];
          state_d = ST_FIN;
        end
      end
      ST_REL_MD1: begin
        state_d = ST_REL_W1;
      end
      ST_REL_W1: begin
        if (div_done) begin
          idx_d   = div_quot[CurveIdxW-1:0];
          rem_d   = div_rem;
          state_d = ST_REL_RDA;
        end
      end
      ST_REL_RDA: begin
        state_d = ST_REL_RDB;
      end
      ST_REL_RDB: begin
        a_d     = rom_data;
        state_d = ST_REL_DIFF;
      end
      ST_REL_DIFF: begin
        diff_d  = (rom_data > a_q) ? rom_data - a_q : '0;
        state_d = ST_REL_MD2;
      end
      ST_REL_MD2: begin
        state_d = ST_REL_W2;
      end
      ST_REL_W2: begin
        if (div_done) begin
          cv_d    = a_q + div_quot[LEVEL_W-1:0];
          state_d = ST_REL_MUL3;
        end
      end
      ST_REL_MUL3: begin
        prod_d  = mul_p[32:0];
        state_d = ST_REL_LVL;
      end
      ST_REL_LVL: begin
        level_d = FULL_LEVEL - prod_q[32:16];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        level_d = lvl_fin;
        phase_d = ph_fin;
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bc_q        <= '0;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      level_q     <= '0;
      run_q       <= 1'b0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bc_q        <= bc_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      level_q     <= level_d;
      run_q       <= run_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_i.cmd;
      play_q <= in_i.playing;
      pos_q  <= in_i.sync_position;
    end
    idx_q  <= idx_d;
    rem_q  <= rem_d;
    a_q    <= a_d;
    diff_q <= diff_d;
    cv_q   <= cv_d;
    prod_q <= prod_d;
    if (out_load) begin
      out_level_q <= lvl_fin;
      out_phase_q <= ph_fin;
      out_flush_q <= flush_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.gate_level    = out_level_q;
  assign out_o.env_phase     = out_phase_q;
  assign out_o.flush_request = out_flush_q;

endmodule

>>> hw/rtl/bsge_chk.sv
// ----------------------------------------------------------------------------
// bsge_chk: port-level checks
// Watches the top-level channels and flags sequencing and range slips.
// ----------------------------------------------------------------------------
module bsge_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [bsge_pkg::LEVEL_W-1:0]  gate_level_i,
  input logic [1:0]                    env_phase_i,
  input logic                          flush_request_i
);
  import bsge_pkg::*;

  // one beat in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a beat is in flight");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> gate_level_i <= FULL_LEVEL)
    else $error("gate level above unity");

  // flush only on a retrigger, which leaves attack or at most hold
  a_flush_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && flush_request_i |-> env_phase_i == PH_ATTACK || env_phase_i == PH_HOLD)
    else $error("flush outside a retrigger");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(gate_level_i) &&
    $stable(env_phase_i) && $stable(flush_request_i))
    else $error("stalled result changed");

endmodule

bind beat_synced_gate_envelope_top bsge_chk u_bsge_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .gate_level_i    (out_o.gate_level),
  .env_phase_i     (out_o.env_phase),
  .flush_request_i (out_o.flush_request)
);
